// ----- hdl/lpfr_pkg.sv -----
// shared types, constants and the crc16 byte step for the frame receiver
// no dependencies; every other file of the block imports this package
package lpfr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 512;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0]  START_SHORT = 8'd2;   // one-byte length follows
	localparam logic [7:0]  START_LONG  = 8'd3;   // two-byte length follows
	localparam logic [7:0]  END_BYTE    = 8'd3;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// wide enough for any count and declared length, plus one
	localparam int unsigned CNT_EXT_W = 17;

	localparam int unsigned TDATA_W = 32;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CRC_BAD  = 2'd1,
		ST_END_BAD  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		PH_WAIT      = 8'b0000_0001,
		PH_LEN_SHORT = 8'b0000_0010,
		PH_LEN_HI    = 8'b0000_0100,
		PH_LEN_LO    = 8'b0000_1000,
		PH_PAYLOAD   = 8'b0001_0000,
		PH_CRC_HI    = 8'b0010_0000,
		PH_CRC_LO    = 8'b0100_0000,
		PH_END       = 8'b1000_0000
	} phase_t;

	// command from the parser to the back end
	typedef struct packed {
		logic        is_end;   // 1 frame end, 0 payload byte
		logic [7:0]  data;
		logic [8:0]  pos;
		status_t     status;   // ST_GOOD on an end means compare crc
		logic [15:0] rx_crc;
		logic [9:0]  len;
	} cmd_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- hdl/length_prefixed_frame_receiver_core.sv -----
// top level of the length-prefixed frame receiver with on-the-fly crc16 check
// depends on lpfr_pkg, lpfr_front, lpfr_queue and lpfr_back
//
// input stream: one received serial byte per transfer on s_tdata
// bytes are ignored until a start byte (2: one-byte length, 3: two-byte
// big-endian length); then payload, big-endian crc16 (poly 0x1021, init 0)
// and end byte 3
// output stream: one record per payload byte (m_tlast low) and one status
// record at the end of each frame (m_tlast high): good, crc mismatch,
// bad end byte, or overflow when the payload exceeds MAX_PAYLOAD
// throughput: one byte per cycle sustained while the sink takes records;
// the parser takes a byte each cycle while the command queue has room, the
// crc unit retires one a cycle while the output register is free; a record
// reaches m_tvalid via the command queue and then the output register (the
// parser writes the queue on the transfer, the crc unit loads the output
// register from it); when the sink stalls, the output register holds, the
// queue fills, and only then s_tready drops; nothing is lost or repeated
// reset (arst_n low) empties the queue and the output register and puts the
// parser back to waiting for a start byte
module length_prefixed_frame_receiver_core #(
	parameter int unsigned MAX_PAYLOAD = lpfr_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned QUEUE_DEPTH = lpfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] payload_byte, [16:8] byte_position, [18:17] frame_status,
	// [28:19] frame_length, [31:29] zero
	output logic [lpfr_pkg::TDATA_W-1:0] m_tdata,
	output logic        m_tlast    // record_type: high on the frame status record
);
	import lpfr_pkg::*;

	// parser to queue
	logic push, push_ready;
	cmd_t push_cmd;

	// queue to crc unit
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	lpfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.push      (push),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	lpfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (cmd_valid),
		.pop       (cmd_pop),
		.pop_cmd   (cmd)
	);

	// crc unit and output register
	lpfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);

endmodule

// ----- hdl/lpfr_front.sv -----
// front end: frame parser that turns each payload byte and each frame end into a command
// depends on lpfr_pkg
module lpfr_front #(
	parameter int unsigned MAX_PAYLOAD = lpfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	output logic              push,
	input  logic              push_ready,
	output lpfr_pkg::cmd_t    push_cmd
);
	import lpfr_pkg::*;

	localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

	phase_t        phase_q, phase_d;
	logic [15:0]   decl_q, decl_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   rx_crc_q, rx_crc_d;

	logic [CNT_EXT_W-1:0] count_ext, count_inc;
	logic                 accept, emit;
	cmd_t                 cmd;

	assign in_ready  = push_ready;
	assign accept    = in_valid & push_ready;
	assign count_ext = CNT_EXT_W'(count_q);
	assign count_inc = count_ext + CNT_EXT_W'(1);

	always_comb begin
		phase_d  = phase_q;
		decl_d   = decl_q;
		count_d  = count_q;
		rx_crc_d = rx_crc_q;
		emit     = 1'b0;
		cmd      = '0;
		unique case (phase_q)
			PH_WAIT: begin
				if (in_byte == START_SHORT) begin
					phase_d = PH_LEN_SHORT;
				end else if (in_byte == START_LONG) begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_SHORT: begin
				decl_d  = {8'h00, in_byte};
				count_d = '0;
				phase_d = (in_byte == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
			end
			PH_LEN_HI: begin
				decl_d  = {in_byte, 8'h00};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				decl_d  = {decl_q[15:8], in_byte};
				count_d = '0;
				phase_d = ({decl_q[15:8], in_byte} == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
				if (count_ext == CNT_EXT_W'(MAX_PAYLOAD)) begin
					// too long: drop the byte and close the frame
					cmd.is_end = 1'b1;
					cmd.status = ST_OVERFLOW;
					cmd.len    = count_ext[9:0];
					phase_d    = PH_WAIT;
				end else begin
					cmd.data = in_byte;
					cmd.pos  = count_ext[8:0];
					count_d  = count_inc[CW-1:0];
					if (count_inc >= CNT_EXT_W'(decl_q)) begin
						phase_d = PH_CRC_HI;
					end
				end
			end
			PH_CRC_HI: begin
				rx_crc_d = {in_byte, 8'h00};
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				rx_crc_d = {rx_crc_q[15:8], in_byte};
				phase_d  = PH_END;
			end
			PH_END: begin
				emit       = 1'b1;
				cmd.is_end = 1'b1;
				cmd.status = (in_byte != END_BYTE) ? ST_END_BAD : ST_GOOD;
				cmd.rx_crc = rx_crc_q;
				cmd.len    = count_ext[9:0];
				phase_d    = PH_WAIT;
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	assign push     = accept & emit;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			decl_q   <= '0;
			count_q  <= '0;
			rx_crc_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			decl_q   <= decl_d;
			count_q  <= count_d;
			rx_crc_q <= rx_crc_d;
		end
	end

endmodule

// ----- hdl/lpfr_queue.sv -----
// short command queue between parser and back end
// depends on lpfr_pkg
module lpfr_queue #(
	parameter int unsigned DEPTH = lpfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  lpfr_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop,
	output lpfr_pkg::cmd_t pop_cmd
);
	import lpfr_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          do_push, do_pop;

	assign push_ready = (fill_q != FW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/lpfr_back.sv -----
// back end: running crc, status resolution and the output register
// depends on lpfr_pkg
module lpfr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  lpfr_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [lpfr_pkg::TDATA_W-1:0] out_data,
	output logic           out_last
);
	import lpfr_pkg::*;

	logic [15:0]        crc_q;
	logic               valid_q;
	logic               last_q;
	logic [TDATA_W-1:0] data_q;
	status_t            status;

	assign cmd_pop = cmd_valid & (~valid_q | out_ready);

	always_comb begin
		status = cmd.status;
		if (cmd.status == ST_GOOD) begin
			status = (crc_q == cmd.rx_crc) ? ST_GOOD : ST_CRC_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				valid_q <= 1'b1;
				// a frame end clears the crc for the next frame
				crc_q   <= cmd.is_end ? 16'h0000 : crc16_byte(crc_q, cmd.data);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			last_q <= cmd.is_end;
			if (cmd.is_end) begin
				data_q <= {3'b000, cmd.len, status, 9'h000, 8'h00};
			end else begin
				data_q <= {3'b000, 10'h000, ST_GOOD, cmd.pos, cmd.data};
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

endmodule

// ----- hdl/lpfr_checker.sv -----
// port-level checks on the frame receiver output stream, bound to the top level
// depends on lpfr_pkg and length_prefixed_frame_receiver_core
module lpfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [lpfr_pkg::TDATA_W-1:0] m_tdata,
	input logic        m_tlast
);
	import lpfr_pkg::*;

	// a stalled record holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output record changed while stalled");

	// payload record carries no status or length
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[28:17] == 12'h000)
		else $error("payload record has status or length bits set");

	// status record carries no byte or position
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[16:0] == 17'h00000)
		else $error("status record has byte or position bits set");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:29] == 3'b000)
		else $error("tdata padding not zero");

endmodule

bind length_prefixed_frame_receiver_core lpfr_checker u_lpfr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
